// ===== sv/acs_pkg.sv =====
// Package for the addition chain search core: widths, limits and FSM states.
// Used by addition_chain_search_core and acs_checker; depends on nothing.
package acs_pkg;

    localparam int MAX_LEN   = 10;
    localparam int ELEM_W    = 10;
    localparam int TDATA_W   = ((ELEM_W + 7) / 8) * 8;
    localparam int LV_W      = $clog2(MAX_LEN + 1);
    localparam int NLV       = MAX_LEN - 2;
    localparam int LVI_W     = (NLV > 1) ? $clog2(NLV) : 1;
    localparam int VADDR_W   = LVI_W + ELEM_W;
    localparam int TAG_W     = 8;
    localparam int REACH_W   = ELEM_W + MAX_LEN;
    localparam int FIRST_LV  = 3;

    localparam logic [TAG_W-1:0]  TAG_MAX  = {TAG_W{1'b1}};
    localparam logic [ELEM_W-1:0] CLR_LAST = {ELEM_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_ENTER,
        S_CLEAR,
        S_CAND,
        S_RDI,
        S_RDJ,
        S_CHK,
        S_NOTF,
        S_EMRD,
        S_EMLD,
        S_EMHOLD
    } t_state;

endpackage

// ===== sv/addition_chain_search_core.sv =====
// Shortest addition chain search by iterative deepening with backtracking.
// Chain elements and per-level visited tags live in synchronous memories.
// Depends on acs_pkg.
//
//  channel  | dir | tdata                  | tlast         | tuser
//  s_axis   | in  | [9:0] target           | -             | -
//  m_axis   | out | [9:0] element          | last element  | found
//
// One target at a time; input tready is high only while idle.
// Each candidate sum is taken in steps (read c[i], read c[j], read previous
// element and visited tag, check and write back); total run time follows the
// size of the search tree.
// Visited tags carry an 8-bit epoch per level: the first entry of a level after
// reset and every 255th entry after that sweep its 1024 tags, one per cycle.
// Results are emitted one beat per element, held until taken downstream.
// Reset (i_rst_n, synchronous, active low) returns the FSM to idle.
module addition_chain_search_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [acs_pkg::TDATA_W-1:0] i_s_tdata,   // [9:0] target, rest zero
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [acs_pkg::TDATA_W-1:0] o_m_tdata,   // [9:0] element, rest zero
    output logic                        o_m_tlast,
    output logic                        o_m_tuser    // [0] found
);

    acs_pkg::t_state r_state, n_state;

    logic [acs_pkg::ELEM_W-1:0] r_n;
    logic [acs_pkg::LV_W-1:0]   r_lim, r_lv, r_j, r_k, r_len;
    logic [acs_pkg::LV_W-1:0]   r_oi [0:acs_pkg::MAX_LEN];
    logic [acs_pkg::LV_W-1:0]   r_ij [0:acs_pkg::MAX_LEN];
    logic [acs_pkg::TAG_W-1:0]  r_ep [0:acs_pkg::NLV-1];
    logic [acs_pkg::ELEM_W-1:0] r_a;
    logic [acs_pkg::ELEM_W:0]   r_s;
    logic [acs_pkg::ELEM_W-1:0] r_clr;
    logic                       r_m_valid, r_m_last, r_m_found;
    logic [acs_pkg::ELEM_W-1:0] r_m_data;

    // chain memory
    logic [acs_pkg::ELEM_W-1:0] cmem [0:acs_pkg::MAX_LEN];
    logic [acs_pkg::ELEM_W-1:0] r_cq;
    logic [acs_pkg::LV_W-1:0]   r_ca;
    logic [acs_pkg::LV_W-1:0]   c_raddr;
    logic                       c_we;
    logic [acs_pkg::ELEM_W-1:0] cval;

    // visited tag memory
    logic [acs_pkg::TAG_W-1:0]   vmem [0:(1 << acs_pkg::VADDR_W)-1];
    logic [acs_pkg::TAG_W-1:0]   r_vq;
    logic [acs_pkg::VADDR_W-1:0] v_raddr, v_waddr;
    logic [acs_pkg::TAG_W-1:0]   v_wdata;
    logic                        v_we;

    logic [acs_pkg::LVI_W-1:0]   lvi;
    logic [acs_pkg::TAG_W-1:0]   ep_cur;
    logic [acs_pkg::LV_W-1:0]    oi_cur, ij_cur;
    logic [acs_pkg::ELEM_W:0]    sum;
    logic [acs_pkg::REACH_W-1:0] reach;
    logic                        skip, s_acc, m_acc;

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign m_acc   = r_m_valid && i_m_tready;
    assign lvi     = acs_pkg::LVI_W'(r_lv - acs_pkg::LV_W'(acs_pkg::FIRST_LV));
    assign ep_cur  = r_ep[lvi];
    assign oi_cur  = r_oi[r_lv];
    assign ij_cur  = r_ij[r_lv];
    assign cval    = (r_ca == acs_pkg::LV_W'(1)) ? acs_pkg::ELEM_W'(1) :
                     (r_ca == acs_pkg::LV_W'(2)) ? acs_pkg::ELEM_W'(2) : r_cq;
    assign sum     = {1'b0, r_a} + {1'b0, cval};
    assign reach   = acs_pkg::REACH_W'(r_s[acs_pkg::ELEM_W-1:0]) << (r_lim - r_lv);
    assign skip    = (r_s > {1'b0, r_n}) || (r_s <= {1'b0, cval}) || (r_vq == ep_cur);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            acs_pkg::S_IDLE:   if (s_acc) n_state = acs_pkg::S_START;
            acs_pkg::S_START: begin
                if (r_n == '0)
                    n_state = acs_pkg::S_NOTF;
                else if (r_n <= acs_pkg::ELEM_W'(2))
                    n_state = acs_pkg::S_EMRD;
                else
                    n_state = acs_pkg::S_ENTER;
            end
            acs_pkg::S_ENTER:  n_state = (ep_cur == acs_pkg::TAG_MAX) ?
                                         acs_pkg::S_CLEAR : acs_pkg::S_CAND;
            acs_pkg::S_CLEAR:  if (r_clr == acs_pkg::CLR_LAST) n_state = acs_pkg::S_CAND;
            acs_pkg::S_CAND: begin
                if (oi_cur != '0)
                    n_state = acs_pkg::S_RDI;
                else if (r_lv == acs_pkg::LV_W'(acs_pkg::FIRST_LV))
                    n_state = (r_lim == acs_pkg::LV_W'(acs_pkg::MAX_LEN)) ?
                              acs_pkg::S_NOTF : acs_pkg::S_ENTER;
            end
            acs_pkg::S_RDI:    n_state = acs_pkg::S_RDJ;
            acs_pkg::S_RDJ:    n_state = acs_pkg::S_CHK;
            acs_pkg::S_CHK: begin
                if (skip)
                    n_state = acs_pkg::S_CAND;
                else if (r_s == {1'b0, r_n})
                    n_state = acs_pkg::S_EMRD;
                else if (r_lv < r_lim && reach >= acs_pkg::REACH_W'(r_n))
                    n_state = acs_pkg::S_ENTER;
                else
                    n_state = acs_pkg::S_CAND;
            end
            acs_pkg::S_NOTF:   n_state = acs_pkg::S_EMHOLD;
            acs_pkg::S_EMRD:   n_state = acs_pkg::S_EMLD;
            acs_pkg::S_EMLD:   n_state = acs_pkg::S_EMHOLD;
            acs_pkg::S_EMHOLD: if (m_acc) n_state = r_m_last ? acs_pkg::S_IDLE
                                                             : acs_pkg::S_EMRD;
            default:           n_state = acs_pkg::S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        c_raddr = r_k;
        c_we    = 1'b0;
        v_raddr = {lvi, sum[acs_pkg::ELEM_W-1:0]};
        v_we    = 1'b0;
        v_waddr = {lvi, r_s[acs_pkg::ELEM_W-1:0]};
        v_wdata = ep_cur;
        case (r_state)
            acs_pkg::S_CAND:  c_raddr = oi_cur;
            acs_pkg::S_RDI:   c_raddr = r_j;
            acs_pkg::S_RDJ:   c_raddr = r_lv - acs_pkg::LV_W'(1);
            acs_pkg::S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = {lvi, r_clr};
                v_wdata = '0;
            end
            acs_pkg::S_CHK: begin
                v_we = !skip;
                c_we = !skip;
            end
            default: c_raddr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (c_we) cmem[r_lv] <= r_s[acs_pkg::ELEM_W-1:0];
        r_cq <= cmem[c_raddr];
        r_ca <= c_raddr;
        if (v_we) vmem[v_waddr] <= v_wdata;
        r_vq <= vmem[v_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= acs_pkg::S_IDLE;
            r_m_valid <= 1'b0;
            for (int e = 0; e < acs_pkg::NLV; e++) r_ep[e] <= acs_pkg::TAG_MAX;
        end else begin
            r_state <= n_state;
            case (r_state)
                acs_pkg::S_IDLE: if (s_acc) r_n <= i_s_tdata[acs_pkg::ELEM_W-1:0];
                acs_pkg::S_START: begin
                    r_len <= acs_pkg::LV_W'(r_n);
                    r_k   <= acs_pkg::LV_W'(1);
                    r_lim <= acs_pkg::LV_W'(acs_pkg::FIRST_LV);
                    r_lv  <= acs_pkg::LV_W'(acs_pkg::FIRST_LV);
                end
                acs_pkg::S_ENTER: begin
                    r_oi[r_lv] <= r_lv - acs_pkg::LV_W'(1);
                    r_ij[r_lv] <= r_lv - acs_pkg::LV_W'(1);
                    r_clr      <= '0;
                    r_ep[lvi]  <= (ep_cur == acs_pkg::TAG_MAX) ? acs_pkg::TAG_W'(1)
                                                               : ep_cur + acs_pkg::TAG_W'(1);
                end
                acs_pkg::S_CLEAR: r_clr <= r_clr + acs_pkg::ELEM_W'(1);
                acs_pkg::S_CAND: begin
                    r_j <= ij_cur;
                    if (oi_cur != '0) begin
                        // advance to the next pair at this level
                        if (ij_cur > acs_pkg::LV_W'(1)) begin
                            r_ij[r_lv] <= ij_cur - acs_pkg::LV_W'(1);
                        end else begin
                            r_oi[r_lv] <= oi_cur - acs_pkg::LV_W'(1);
                            r_ij[r_lv] <= oi_cur - acs_pkg::LV_W'(1);
                        end
                    end else if (r_lv == acs_pkg::LV_W'(acs_pkg::FIRST_LV)) begin
                        r_lim <= r_lim + acs_pkg::LV_W'(1);
                    end else begin
                        r_lv <= r_lv - acs_pkg::LV_W'(1);
                    end
                end
                acs_pkg::S_RDI: r_a <= cval;
                acs_pkg::S_RDJ: r_s <= sum;
                acs_pkg::S_CHK: begin
                    if (!skip) begin
                        if (r_s == {1'b0, r_n}) begin
                            r_len <= r_lv;
                            r_k   <= acs_pkg::LV_W'(1);
                        end else if (r_lv < r_lim && reach >= acs_pkg::REACH_W'(r_n)) begin
                            r_lv <= r_lv + acs_pkg::LV_W'(1);
                        end
                    end
                end
                acs_pkg::S_NOTF: begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= '0;
                    r_m_last  <= 1'b1;
                    r_m_found <= 1'b0;
                end
                acs_pkg::S_EMLD: begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= cval;
                    r_m_last  <= (r_k == r_len);
                    r_m_found <= 1'b1;
                end
                acs_pkg::S_EMHOLD: begin
                    if (m_acc) begin
                        r_m_valid <= 1'b0;
                        r_k       <= r_k + acs_pkg::LV_W'(1);
                    end
                end
                default: r_m_valid <= r_m_valid;
            endcase
        end
    end

    assign o_s_tready = (r_state == acs_pkg::S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = acs_pkg::TDATA_W'(r_m_data);
    assign o_m_tlast  = r_m_last;
    assign o_m_tuser  = r_m_found;

endmodule

// ===== sv/acs_checker.sv =====
// Port-level checks for addition_chain_search_core, bound into that module.
// Depends on acs_pkg.
module acs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [acs_pkg::TDATA_W-1:0] o_m_tdata,
    input logic                        o_m_tlast,
    input logic                        o_m_tuser
);

    // a failed search is one zero beat that closes the run
    a_notfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast && o_m_tdata == '0)
        else $error("not-found beat malformed");

    a_found_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata != '0)
        else $error("zero element in found chain");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input taken while results pending");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("ready held after accept");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled beat changed");

endmodule

bind addition_chain_search_core acs_checker u_acs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
